// ===== design/array_linked_list_engine_top_macros.svh =====
// Assertion macros for the linked list engine.
`ifndef ARRAY_LINKED_LIST_ENGINE_TOP_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_TOP_MACROS_SVH
`ifndef SYNTH
`define ALLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("alle assertion failed");
`define ALLE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("alle assertion failed");
`else
`define ALLE_ASSERT(lbl, prop)
`define ALLE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/alle_pkg.sv =====
package alle_pkg;

  // Default sizes of the node store.
  localparam int unsigned DefCapacity = 128;
  localparam int unsigned DefKeyWidth = 32;

  // Operation codes.
  localparam logic [2:0] K_APPEND = 3'd0;
  localparam logic [2:0] K_INSERT = 3'd1;
  localparam logic [2:0] K_DELPOS = 3'd2;
  localparam logic [2:0] K_DELKEY = 3'd3;
  localparam logic [2:0] K_SEARCH = 3'd4;
  localparam logic [2:0] K_READ   = 3'd5;

  // Status codes.
  localparam logic [2:0] S_OK     = 3'd0;
  localparam logic [2:0] S_FULL   = 3'd1;
  localparam logic [2:0] S_EMPTY  = 3'd2;
  localparam logic [2:0] S_BADPOS = 3'd3;
  localparam logic [2:0] S_NOKEY  = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] item_key;
    logic [31:0]        item_payload;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] found_key;
    logic [31:0]        found_payload;
    logic [7:0]         entry_total;
  } out_rsp_t;

endpackage

// ===== design/alle_node_store.sv =====
module alle_node_store #(
  parameter int unsigned CAPACITY  = alle_pkg::DefCapacity,
  parameter int unsigned KEY_WIDTH = alle_pkg::DefKeyWidth,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned IW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic [AW-1:0]        rd_addr_i,
  input  logic                 lk_we_i,
  input  logic [AW-1:0]        lk_waddr_i,
  input  logic [IW-1:0]        lk_wdata_i,
  input  logic                 nd_we_i,
  input  logic [AW-1:0]        nd_waddr_i,
  input  logic [KEY_WIDTH-1:0] nd_wkey_i,
  input  logic [31:0]          nd_wpay_i,
  output logic [IW-1:0]        lk_rdata_o,
  output logic [KEY_WIDTH-1:0] key_rdata_o,
  output logic [31:0]          pay_rdata_o
);

  logic [IW-1:0]        link_mem [CAPACITY];
  logic [KEY_WIDTH-1:0] key_mem  [CAPACITY];
  logic [31:0]          pay_mem  [CAPACITY];

  // Link memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (lk_we_i) begin
      link_mem[lk_waddr_i] <= lk_wdata_i;
    end
    lk_rdata_o <= link_mem[rd_addr_i];
  end

  // Key and payload memories share the write and read addresses.
  always_ff @(posedge clk_i) begin
    if (nd_we_i) begin
      key_mem[nd_waddr_i] <= nd_wkey_i;
      pay_mem[nd_waddr_i] <= nd_wpay_i;
    end
    key_rdata_o <= key_mem[rd_addr_i];
    pay_rdata_o <= pay_mem[rd_addr_i];
  end

endmodule

// ===== design/alle_seq.sv =====
module alle_seq #(
  parameter int unsigned CAPACITY  = alle_pkg::DefCapacity,
  parameter int unsigned KEY_WIDTH = alle_pkg::DefKeyWidth,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned IW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  alle_pkg::in_req_t    in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output alle_pkg::out_rsp_t   out_rsp_o,
  output logic [AW-1:0]        rd_addr_o,
  output logic                 lk_we_o,
  output logic [AW-1:0]        lk_waddr_o,
  output logic [IW-1:0]        lk_wdata_o,
  output logic                 nd_we_o,
  output logic [AW-1:0]        nd_waddr_o,
  output logic [KEY_WIDTH-1:0] nd_wkey_o,
  output logic [31:0]          nd_wpay_o,
  input  logic [IW-1:0]        lk_rdata_i,
  input  logic [KEY_WIDTH-1:0] key_rdata_i,
  input  logic [31:0]          pay_rdata_i
);

  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_FREE_RD = 4'd2;
  localparam logic [3:0] ST_FREE_WR = 4'd3;
  localparam logic [3:0] ST_WALK_RD = 4'd4;
  localparam logic [3:0] ST_WALK_EV = 4'd5;
  localparam logic [3:0] ST_NODE_RD = 4'd6;
  localparam logic [3:0] ST_NODE_EV = 4'd7;
  localparam logic [3:0] ST_LINK_WR = 4'd8;
  localparam logic [3:0] ST_GIVE    = 4'd9;
  localparam logic [3:0] ST_DONE    = 4'd10;

  logic [3:0]           state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [IW-1:0]        head_q, head_d;
  logic [IW-1:0]        free_q, free_d;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic [2:0]           op_q, op_d;
  logic [7:0]           pos_q, pos_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [31:0]          pay_q, pay_d;
  logic [IW-1:0]        cur_q, cur_d;
  logic [IW-1:0]        prev_q, prev_d;
  logic [IW-1:0]        new_q, new_d;
  logic [IW-1:0]        steps_q, steps_d;
  logic                 phase_q, phase_d;
  logic                 hit_q, hit_d;
  logic [2:0]           status_q, status_d;
  logic [31:0]          fkey_q, fkey_d;
  logic [31:0]          fpay_q, fpay_d;

  logic                 key_hit;
  logic                 is_full;
  logic                 is_empty;
  logic                 pos_ok;
  logic [3:0]           walk_next;
  logic signed [63:0]   key_sx;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      head_q  <= NIL;
      free_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      free_q  <= free_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    key_q    <= key_d;
    pay_q    <= pay_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    new_q    <= new_d;
    steps_q  <= steps_d;
    phase_q  <= phase_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    fkey_q   <= fkey_d;
    fpay_q   <= fpay_d;
  end

  // Shared compare and status decode.
  assign key_hit   = (key_rdata_i == key_q);
  assign is_full   = (cnt_q >= NIL);
  assign is_empty  = (cnt_q == '0);
  assign pos_ok    = (in_req_i.position != 8'd0) &&
                     (32'(in_req_i.position) <= 32'(cnt_q));
  assign walk_next = (op_q == alle_pkg::K_APPEND) ? ST_LINK_WR : ST_NODE_RD;
  assign key_sx    = 64'(signed'(key_rdata_i));

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    head_d   = head_q;
    free_d   = free_q;
    cnt_d    = cnt_q;
    op_d     = op_q;
    pos_d    = pos_q;
    key_d    = key_q;
    pay_d    = pay_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    new_d    = new_q;
    steps_d  = steps_q;
    phase_d  = phase_q;
    hit_d    = hit_q;
    status_d = status_q;
    fkey_d   = fkey_q;
    fpay_d   = fpay_q;

    rd_addr_o  = cur_q[AW-1:0];
    lk_we_o    = 1'b0;
    lk_waddr_o = cur_q[AW-1:0];
    lk_wdata_o = new_q;
    nd_we_o    = 1'b0;
    nd_waddr_o = free_q[AW-1:0];
    nd_wkey_o  = key_q;
    nd_wpay_o  = pay_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;

    case (state_q)
      // Build the initial free chain, one link per cycle.
      ST_CLR: begin
        lk_we_o    = 1'b1;
        lk_waddr_o = clr_q;
        lk_wdata_o = IW'(clr_q) + IW'(1);
        if (clr_q == AW'(CAPACITY - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      // Take a request and check the quick cases.
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d     = in_req_i.kind;
          pos_d    = in_req_i.position;
          key_d    = KEY_WIDTH'($unsigned(in_req_i.item_key));
          pay_d    = in_req_i.item_payload;
          fkey_d   = '0;
          fpay_d   = '0;
          status_d = alle_pkg::S_OK;
          phase_d  = 1'b0;
          hit_d    = 1'b0;
          cur_d    = head_q;
          prev_d   = NIL;
          steps_d  = IW'(32'(in_req_i.position) - 32'd2);
          case (in_req_i.kind)
            alle_pkg::K_APPEND: begin
              if (is_full) begin
                status_d = alle_pkg::S_FULL;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_FREE_RD;
              end
            end
            alle_pkg::K_INSERT: begin
              if (is_full) begin
                status_d = alle_pkg::S_FULL;
                state_d  = ST_DONE;
              end else if (!pos_ok) begin
                status_d = alle_pkg::S_BADPOS;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_FREE_RD;
              end
            end
            alle_pkg::K_DELPOS: begin
              if (is_empty) begin
                status_d = alle_pkg::S_EMPTY;
                state_d  = ST_DONE;
              end else if (!pos_ok) begin
                status_d = alle_pkg::S_BADPOS;
                state_d  = ST_DONE;
              end else if (in_req_i.position <= 8'd2) begin
                state_d = ST_NODE_RD;
              end else begin
                state_d = ST_WALK_RD;
              end
            end
            alle_pkg::K_DELKEY, alle_pkg::K_SEARCH: begin
              if (is_empty) begin
                status_d = alle_pkg::S_EMPTY;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_NODE_RD;
              end
            end
            alle_pkg::K_READ: begin
              steps_d = IW'(32'(in_req_i.position) - 32'd1);
              if (is_empty) begin
                status_d = alle_pkg::S_EMPTY;
                state_d  = ST_DONE;
              end else if (!pos_ok) begin
                status_d = alle_pkg::S_BADPOS;
                state_d  = ST_DONE;
              end else if (in_req_i.position == 8'd1) begin
                state_d = ST_NODE_RD;
              end else begin
                state_d = ST_WALK_RD;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // Pop a node from the free stack.
      ST_FREE_RD: begin
        rd_addr_o = free_q[AW-1:0];
        state_d   = ST_FREE_WR;
      end

      ST_FREE_WR: begin
        nd_we_o    = 1'b1;
        lk_we_o    = 1'b1;
        lk_waddr_o = free_q[AW-1:0];
        lk_wdata_o = (op_q == alle_pkg::K_INSERT && pos_q == 8'd1) ? head_q : NIL;
        new_d      = free_q;
        free_d     = lk_rdata_i;
        cur_d      = head_q;
        if (op_q == alle_pkg::K_APPEND) begin
          if (head_q == NIL) begin
            head_d  = free_q;
            cnt_d   = cnt_q + IW'(1);
            state_d = ST_DONE;
          end else begin
            steps_d = cnt_q - IW'(1);
            state_d = (cnt_q == IW'(1)) ? ST_LINK_WR : ST_WALK_RD;
          end
        end else if (pos_q == 8'd1) begin
          head_d  = free_q;
          cnt_d   = cnt_q + IW'(1);
          state_d = ST_DONE;
        end else begin
          steps_d = IW'(32'(pos_q) - 32'd2);
          state_d = (pos_q == 8'd2) ? ST_NODE_RD : ST_WALK_RD;
        end
      end

      // Follow one link: read it in ST_WALK_RD, take it in ST_WALK_EV.
      ST_WALK_RD: begin
        state_d = ST_WALK_EV;
      end

      ST_WALK_EV: begin
        cur_d   = lk_rdata_i;
        steps_d = steps_q - IW'(1);
        state_d = (steps_q == IW'(1)) ? walk_next : ST_WALK_RD;
      end

      // Hook the new node behind the current node.
      ST_LINK_WR: begin
        lk_we_o    = 1'b1;
        lk_waddr_o = cur_q[AW-1:0];
        lk_wdata_o = new_q;
        cnt_d      = cnt_q + IW'(1);
        state_d    = ST_DONE;
      end

      ST_NODE_RD: begin
        state_d = ST_NODE_EV;
      end

      // Act on the node that was just read.
      ST_NODE_EV: begin
        case (op_q)
          alle_pkg::K_INSERT: begin
            lk_we_o    = 1'b1;
            lk_waddr_o = new_q[AW-1:0];
            lk_wdata_o = lk_rdata_i;
            state_d    = ST_LINK_WR;
          end
          alle_pkg::K_DELPOS: begin
            if (pos_q == 8'd1) begin
              head_d  = lk_rdata_i;
              new_d   = cur_q;
              state_d = ST_GIVE;
            end else if (!phase_q) begin
              prev_d  = cur_q;
              new_d   = lk_rdata_i;
              cur_d   = lk_rdata_i;
              phase_d = 1'b1;
              state_d = ST_NODE_RD;
            end else begin
              lk_we_o    = 1'b1;
              lk_waddr_o = prev_q[AW-1:0];
              lk_wdata_o = lk_rdata_i;
              state_d    = ST_GIVE;
            end
          end
          alle_pkg::K_READ: begin
            fkey_d  = key_sx[31:0];
            fpay_d  = pay_rdata_i;
            state_d = ST_DONE;
          end
          alle_pkg::K_SEARCH: begin
            if (key_hit) begin
              fkey_d  = key_sx[31:0];
              fpay_d  = pay_rdata_i;
              state_d = ST_DONE;
            end else begin
              cur_d = lk_rdata_i;
              if (lk_rdata_i == NIL) begin
                status_d = alle_pkg::S_NOKEY;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_NODE_RD;
              end
            end
          end
          alle_pkg::K_DELKEY: begin
            if (key_hit) begin
              if (!phase_q || prev_q == NIL) begin
                head_d = lk_rdata_i;
              end else begin
                lk_we_o    = 1'b1;
                lk_waddr_o = prev_q[AW-1:0];
                lk_wdata_o = lk_rdata_i;
              end
              new_d   = cur_q;
              hit_d   = 1'b1;
              state_d = ST_GIVE;
            end else begin
              phase_d = 1'b1;
              prev_d  = cur_q;
              cur_d   = lk_rdata_i;
              if (lk_rdata_i == NIL) begin
                status_d = hit_q ? alle_pkg::S_OK : alle_pkg::S_NOKEY;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_NODE_RD;
              end
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      // Push the removed node onto the free stack.
      ST_GIVE: begin
        lk_we_o    = 1'b1;
        lk_waddr_o = new_q[AW-1:0];
        lk_wdata_o = free_q;
        free_d     = new_q;
        cnt_d      = cnt_q - IW'(1);
        if (op_q == alle_pkg::K_DELKEY && !phase_q) begin
          cur_d   = head_q;
          state_d = (head_q == NIL) ? ST_DONE : ST_NODE_RD;
        end else begin
          state_d = ST_DONE;
        end
      end

      // Hold the result until it is taken.
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result fields come straight from registers.
  always_comb begin
    out_rsp_o.status        = status_q;
    out_rsp_o.found_key     = signed'(fkey_q);
    out_rsp_o.found_payload = fpay_q;
    out_rsp_o.entry_total   = 8'(cnt_q);
  end

endmodule

// ===== design/array_linked_list_engine_top.sv =====
// Linked list engine over a store of CAPACITY nodes with a free-node stack.
// One request at a time; a walk reads each node in a read state and acts on it
// in an evaluate state, and the result is held until taken.
// After reset a clearing pass writes one link per node to build the free chain,
// and no request is accepted during it. The list then reads as empty.
`include "array_linked_list_engine_top_macros.svh"

module array_linked_list_engine_top #(
  parameter int unsigned CAPACITY  = alle_pkg::DefCapacity,
  parameter int unsigned KEY_WIDTH = alle_pkg::DefKeyWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  alle_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output alle_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned IW = $clog2(CAPACITY + 1);

  logic [AW-1:0]        rd_addr;
  logic                 lk_we;
  logic [AW-1:0]        lk_waddr;
  logic [IW-1:0]        lk_wdata;
  logic                 nd_we;
  logic [AW-1:0]        nd_waddr;
  logic [KEY_WIDTH-1:0] nd_wkey;
  logic [31:0]          nd_wpay;
  logic [IW-1:0]        lk_rdata;
  logic [KEY_WIDTH-1:0] key_rdata;
  logic [31:0]          pay_rdata;

  // Sequencer that walks the list.
  alle_seq #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .rd_addr_o  (rd_addr),
    .lk_we_o    (lk_we),
    .lk_waddr_o (lk_waddr),
    .lk_wdata_o (lk_wdata),
    .nd_we_o    (nd_we),
    .nd_waddr_o (nd_waddr),
    .nd_wkey_o  (nd_wkey),
    .nd_wpay_o  (nd_wpay),
    .lk_rdata_i (lk_rdata),
    .key_rdata_i(key_rdata),
    .pay_rdata_i(pay_rdata)
  );

  // Node store.
  alle_node_store #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_store (
    .clk_i      (clk_i),
    .rd_addr_i  (rd_addr),
    .lk_we_i    (lk_we),
    .lk_waddr_i (lk_waddr),
    .lk_wdata_i (lk_wdata),
    .nd_we_i    (nd_we),
    .nd_waddr_i (nd_waddr),
    .nd_wkey_i  (nd_wkey),
    .nd_wpay_i  (nd_wpay),
    .lk_rdata_o (lk_rdata),
    .key_rdata_o(key_rdata),
    .pay_rdata_o(pay_rdata)
  );

  // A pending result blocks new requests.
  `ALLE_ASSERT_ALWAYS(a_result_blocks_req, out_valid_o |-> in_stall_o)
  // An accepted request closes the input until its result is taken.
  `ALLE_ASSERT(a_req_then_busy, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // A taken result is not shown again.
  `ALLE_ASSERT(a_result_once, (out_valid_o && !out_stall_i) |=> !out_valid_o)

endmodule

// ===== dv/alle_checker.sv =====
module alle_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  alle_pkg::in_req_t  in_req_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  alle_pkg::out_rsp_t out_rsp_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned Cap = alle_pkg::DefCapacity;
  localparam int unsigned Nil = Cap;

  // Shadow copy of the node store and its free stack.
  logic signed [31:0] shadow_key[Cap];
  logic [31:0]        shadow_pay[Cap];
  int unsigned        shadow_link[Cap];
  int unsigned        list_head;
  int unsigned        free_top;
  int unsigned        list_len;
  int                 fails;

  alle_pkg::out_rsp_t expected_rsp_q[$];

  assign pending_o    = expected_rsp_q.size();
  assign fail_count_o = fails;

  function automatic int unsigned link_after(int unsigned i);
    return (i < Nil) ? shadow_link[i] : Nil;
  endfunction

  function automatic int unsigned node_at_pos(int unsigned p);
    int unsigned n;
    n = list_head;
    for (int unsigned i = 1; i < p; i++) n = link_after(n);
    return n;
  endfunction

  // Return a node to the top of the free stack.
  function automatic void release_node(int unsigned n);
    if (n >= Nil) return;
    shadow_link[n] = free_top;
    free_top = n;
    if (list_len > 0) list_len--;
  endfunction

  // Pop a node from the free stack and fill it.
  function automatic int unsigned claim_node(logic [31:0] k, logic [31:0] pl);
    int unsigned f;
    f = free_top;
    free_top = shadow_link[f];
    shadow_key[f] = k;
    shadow_pay[f] = pl;
    shadow_link[f] = Nil;
    return f;
  endfunction

  function automatic alle_pkg::out_rsp_t apply_list_op(alle_pkg::in_req_t rq);
    alle_pkg::out_rsp_t r;
    int unsigned n, prv, cur, pos;
    bit hit;
    r = '0;
    r.status = alle_pkg::S_OK;
    pos = 32'(rq.position);
    case (rq.kind)
      alle_pkg::K_APPEND: begin
        if (list_len >= Nil) r.status = alle_pkg::S_FULL;
        else begin
          n = claim_node(rq.item_key, rq.item_payload);
          if (list_head >= Nil) list_head = n;
          else shadow_link[node_at_pos(list_len)] = n;
          list_len++;
        end
      end
      alle_pkg::K_INSERT: begin
        if (list_len >= Nil) r.status = alle_pkg::S_FULL;
        else if (pos < 1 || pos > list_len) r.status = alle_pkg::S_BADPOS;
        else begin
          n = claim_node(rq.item_key, rq.item_payload);
          if (pos == 1) begin
            shadow_link[n] = list_head;
            list_head = n;
          end else begin
            prv = node_at_pos(pos - 1);
            shadow_link[n] = link_after(prv);
            shadow_link[prv] = n;
          end
          list_len++;
        end
      end
      alle_pkg::K_DELPOS: begin
        if (list_len == 0) r.status = alle_pkg::S_EMPTY;
        else if (pos < 1 || pos > list_len) r.status = alle_pkg::S_BADPOS;
        else begin
          if (pos == 1) begin
            n = list_head;
            list_head = link_after(n);
          end else begin
            prv = node_at_pos(pos - 1);
            n = link_after(prv);
            shadow_link[prv] = link_after(n);
          end
          release_node(n);
        end
      end
      alle_pkg::K_DELKEY: begin
        if (list_len == 0) r.status = alle_pkg::S_EMPTY;
        else begin
          hit = 0;
          // Strip every match at the head, then the first later one.
          while (list_head < Nil && shadow_key[list_head] == rq.item_key) begin
            n = list_head;
            list_head = shadow_link[n];
            release_node(n);
            hit = 1;
          end
          prv = Nil;
          cur = list_head;
          while (cur < Nil) begin
            if (shadow_key[cur] == rq.item_key) begin
              if (prv >= Nil) list_head = shadow_link[cur];
              else shadow_link[prv] = shadow_link[cur];
              release_node(cur);
              hit = 1;
              break;
            end
            prv = cur;
            cur = shadow_link[cur];
          end
          if (!hit) r.status = alle_pkg::S_NOKEY;
        end
      end
      alle_pkg::K_SEARCH: begin
        if (list_len == 0) r.status = alle_pkg::S_EMPTY;
        else begin
          r.status = alle_pkg::S_NOKEY;
          for (cur = list_head; cur < Nil; cur = shadow_link[cur]) begin
            if (shadow_key[cur] == rq.item_key) begin
              r.status = alle_pkg::S_OK;
              r.found_key = shadow_key[cur];
              r.found_payload = shadow_pay[cur];
              break;
            end
          end
        end
      end
      alle_pkg::K_READ: begin
        if (list_len == 0) r.status = alle_pkg::S_EMPTY;
        else if (pos < 1 || pos > list_len) r.status = alle_pkg::S_BADPOS;
        else begin
          n = node_at_pos(pos);
          r.found_key = shadow_key[n];
          r.found_payload = shadow_pay[n];
        end
      end
      default: ;
    endcase
    r.entry_total = list_len[7:0];
    return r;
  endfunction

  initial begin
    for (int unsigned i = 0; i < Cap; i++) begin
      shadow_key[i] = '0;
      shadow_pay[i] = '0;
      shadow_link[i] = i + 1;
    end
    list_head = Nil;
    free_top = 0;
    list_len = 0;
    fails = 0;
  end

  // Predict on each accepted request; compare on each accepted result.
  always @(posedge clk_i) begin
    alle_pkg::out_rsp_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) expected_rsp_q.push_back(apply_list_op(in_req_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected result %p", out_rsp_i);
          fails++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp_i.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, out_rsp_i.status);
            fails++;
          end
          if (out_rsp_i.found_key !== want.found_key) begin
            $error("found_key exp %0d got %0d", want.found_key, out_rsp_i.found_key);
            fails++;
          end
          if (out_rsp_i.found_payload !== want.found_payload) begin
            $error("found_payload exp %h got %h", want.found_payload,
                   out_rsp_i.found_payload);
            fails++;
          end
          if (out_rsp_i.entry_total !== want.entry_total) begin
            $error("entry_total exp %0d got %0d", want.entry_total,
                   out_rsp_i.entry_total);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid = 0;
  logic               in_stall;
  alle_pkg::in_req_t  in_req = '0;
  logic               out_valid;
  logic               out_stall = 1;
  alle_pkg::out_rsp_t out_rsp;
  int                 fail_count, pending;
  bit                 hold_off = 0;
  bit                 hold_done = 0;

  // Keys in use, so that search and delete often hit.
  logic signed [31:0] key_pool[$];
  int unsigned        len_guess = 0;

  array_linked_list_engine_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_rsp_o(out_rsp)
  );

  alle_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_rsp_i(out_rsp),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Offer one request and wait until it is taken.
  task automatic send_request(logic [2:0] k, logic [7:0] p, logic [31:0] key,
                              logic [31:0] pl);
    int unsigned g;
    g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_req <= '{kind: k, position: p, item_key: key, item_payload: pl};
    in_valid <= 1;
    do @(posedge clk_i); while (in_stall);
  endtask

  function automatic logic [31:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom();
  endfunction

  task automatic random_request();
    logic [2:0] k;
    logic [7:0] p;
    logic [31:0] key;
    int unsigned r;
    r = $urandom_range(0, 99);
    // Bias toward growth when short and toward removal when long.
    if (r < 30 + (len_guess < 64 ? 15 : 0)) k = alle_pkg::K_APPEND;
    else if (r < 50) k = alle_pkg::K_INSERT;
    else if (r < 62 + (len_guess > 100 ? 15 : 0)) k = alle_pkg::K_DELPOS;
    else if (r < 74) k = alle_pkg::K_DELKEY;
    else if (r < 86) k = alle_pkg::K_SEARCH;
    else if (r < 98) k = alle_pkg::K_READ;
    else k = 3'($urandom_range(6, 7));
    p = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(1, len_guess + 1));
    key = pick_key();
    if (k == alle_pkg::K_APPEND || k == alle_pkg::K_INSERT) begin
      if (key_pool.size() < 32) key_pool.push_back(key);
      if (len_guess < 128) len_guess++;
    end
    if ((k == alle_pkg::K_DELPOS || k == alle_pkg::K_DELKEY) && len_guess > 0) len_guess--;
    send_request(k, p, key, $urandom());
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_off && !hold_done) begin
        out_stall <= 1;
        repeat (300) @(posedge clk_i);
        hold_done = 1;
      end else if ($urandom_range(0, 30) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("[array_linked_list_engine_top] ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    // Directed: empty-list cases, then a short list and its edge cases.
    send_request(alle_pkg::K_DELPOS, 1, 0, 0);
    send_request(alle_pkg::K_DELKEY, 0, 0, 0);
    send_request(alle_pkg::K_SEARCH, 0, 5, 0);
    send_request(alle_pkg::K_READ, 1, 0, 0);
    send_request(alle_pkg::K_INSERT, 1, 1, 1);
    send_request(3'd7, 8'hff, 32'hffffffff, 32'hffffffff);
    send_request(alle_pkg::K_APPEND, 0, 32'h80000000, 32'h0);
    send_request(alle_pkg::K_APPEND, 0, 32'h7fffffff, 32'hffffffff);
    send_request(alle_pkg::K_APPEND, 0, 32'h80000000, 32'h5);
    send_request(alle_pkg::K_INSERT, 1, 32'hffffffff, 32'ha5a5a5a5);
    send_request(alle_pkg::K_INSERT, 4, 7, 7);
    send_request(alle_pkg::K_INSERT, 0, 7, 7);
    send_request(alle_pkg::K_INSERT, 6, 7, 7);
    send_request(alle_pkg::K_READ, 0, 0, 0);
    send_request(alle_pkg::K_READ, 5, 0, 0);
    send_request(alle_pkg::K_READ, 8'hff, 0, 0);
    send_request(alle_pkg::K_SEARCH, 0, 32'h7fffffff, 0);
    send_request(alle_pkg::K_SEARCH, 0, 12345, 0);
    send_request(alle_pkg::K_DELKEY, 0, 7, 0);
    send_request(alle_pkg::K_DELKEY, 0, 32'h80000000, 0);
    send_request(alle_pkg::K_DELKEY, 0, 999, 0);
    send_request(alle_pkg::K_DELPOS, 9, 0, 0);
    send_request(alle_pkg::K_DELPOS, 2, 0, 0);
    len_guess = 2;
    // Sender pause until every result has come, then a long receiver hold-off.
    in_valid <= 0;
    wait (pending == 0);
    hold_off = 1;
    repeat (6) send_request(alle_pkg::K_APPEND, 0, $urandom(), $urandom());
    len_guess += 6;
    // Fill to capacity and hit the full case.
    for (int i = 0; i < 130; i++) send_request(alle_pkg::K_APPEND, 0, $urandom(), $urandom());
    send_request(alle_pkg::K_INSERT, 1, 1, 1);
    send_request(alle_pkg::K_READ, 128, 0, 0);
    send_request(alle_pkg::K_DELPOS, 128, 0, 0);
    len_guess = 127;
    for (int i = 0; i < 1500; i++) random_request();
    in_valid <= 0;
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("[array_linked_list_engine_top] OK");
    else $display("[array_linked_list_engine_top] ERROR");
    $finish;
  end

endmodule

// ===== array_linked_list_engine_top.f =====
+incdir+design
design/alle_pkg.sv
design/alle_node_store.sv
design/alle_seq.sv
design/array_linked_list_engine_top.sv
dv/alle_checker.sv
dv/testbench.sv
